[rtl/ipvs_pkg.sv]
// ----------------------------------------------------------------------------
// Irrigation pump and valve sequencer package
// Command codes, register indexes, sequencer state type and its reset value.
// ----------------------------------------------------------------------------
package ipvs_pkg;

    typedef enum logic [2:0] {
        CMD_TICK  = 3'd0,
        CMD_SOIL  = 3'd1,
        CMD_LIGHT = 3'd2,
        CMD_CLOCK = 3'd3,
        CMD_PUMP  = 3'd4,
        CMD_VALVE1 = 3'd5,
        CMD_VALVE2 = 3'd6,
        CMD_MODE  = 3'd7
    } cmd_t;

    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_SOIL_THRESHOLD  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LIGHT_THRESHOLD = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_AUTO_OFF        = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SCHEDULE1       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SCHEDULE2       = 3'd4;

    localparam logic [6:0]  SOIL_THRESHOLD_RESET  = 7'd40;
    localparam logic [15:0] LIGHT_THRESHOLD_RESET = 16'd800;
    localparam logic [15:0] AUTO_OFF_RESET        = 16'd0;
    localparam logic [10:0] SLOT_UNSET            = 11'd1440;
    localparam logic [5:0]  DAY_NONE              = 6'd63;
    localparam logic [5:0]  MINUTES_PER_HOUR      = 6'd60;

    localparam int TICK_W = 2;

    typedef struct packed {
        logic              pump;
        logic [1:0]        valve;
        logic              start_wait;
        logic [TICK_W-1:0] start_ticks;
        logic              stop_wait;
        logic [TICK_W-1:0] stop_ticks;
        logic [1:0]        marks;
        logic [3:0]        zone_dry;
        logic [15:0]       light;
        logic [1:0]        watered;
        logic [5:0]        last_day;
        logic [15:0]       auto_left;
        logic              mode;
    } seq_state_t;

    localparam seq_state_t STATE_RESET = '{
        pump:        1'b0,
        valve:       2'b00,
        start_wait:  1'b0,
        start_ticks: '0,
        stop_wait:   1'b0,
        stop_ticks:  '0,
        marks:       2'b00,
        zone_dry:    4'b0000,
        light:       16'd0,
        watered:     2'b00,
        last_day:    DAY_NONE,
        auto_left:   16'd0,
        mode:        1'b0
    };

endpackage

[rtl/irrigation_pump_valve_sequencer.sv]
// ----------------------------------------------------------------------------
// Irrigation pump and valve sequencer
// Drives one pump and two valves from a stream of tick, sensor, clock, switch
// and mode events; one result with the relay drives follows each event.
//
//   channel  | signals                          | direction
//   ---------+----------------------------------+----------
//   item     | item_valid, item_stall, fields   | in
//   result   | result_valid, result_stall, ...  | out
//   cfg      | cfg_valid, cfg_ready, index/data | in
//
// One event per cycle while result_stall is low; each event passes from the input register to
// the result register, with one step of flag and counter logic between them.
// Reset clears the state and loads the register defaults; no clearing pass.
// A stalled result holds, the input register keeps one more transfer, then
// item_stall rises until the result is taken.
// ----------------------------------------------------------------------------
module irrigation_pump_valve_sequencer #(
    parameter int PUMP_DELAY_TICKS = 2,
    parameter int ZONES            = 3
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        item_valid,
    output logic        item_stall,
    input  logic [2:0]  command,
    input  logic [1:0]  zone,
    input  logic [9:0]  soil_tenths,
    input  logic [15:0] lux,
    input  logic [4:0]  clock_hour,
    input  logic [5:0]  clock_minute,
    input  logic [4:0]  clock_day,
    input  logic        switch_value,

    output logic        result_valid,
    input  logic        result_stall,
    output logic        pump_on,
    output logic        valve1_on,
    output logic        valve2_on,
    output logic        start_pending,
    output logic        stop_pending,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [ipvs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0] cfg_data
);

    localparam logic [ipvs_pkg::TICK_W-1:0] DELAY = ipvs_pkg::TICK_W'(PUMP_DELAY_TICKS);
    localparam logic [2:0] ZONE_LIMIT = 3'(ZONES);

    // configuration
    logic [6:0]  soil_threshold_reg;
    logic [15:0] light_threshold_reg;
    logic [15:0] auto_off_reg;
    logic [10:0] schedule1_reg;
    logic [10:0] schedule2_reg;

    // input register
    logic        stage_valid_reg;
    logic [2:0]  command_reg;
    logic [1:0]  zone_reg;
    logic [9:0]  soil_reg;
    logic [15:0] lux_reg;
    logic [4:0]  hour_reg;
    logic [5:0]  minute_reg;
    logic [4:0]  day_reg;
    logic        switch_reg;

    // state and result register
    ipvs_pkg::seq_state_t state_reg, state_next;
    logic       result_valid_reg;
    logic [4:0] result_reg, result_next;

    logic advance;
    logic take;

    assign cfg_ready  = 1'b1;
    assign advance    = !result_valid_reg || !result_stall;
    assign take       = stage_valid_reg && advance;
    assign item_stall = stage_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            soil_threshold_reg  <= ipvs_pkg::SOIL_THRESHOLD_RESET;
            light_threshold_reg <= ipvs_pkg::LIGHT_THRESHOLD_RESET;
            auto_off_reg        <= ipvs_pkg::AUTO_OFF_RESET;
            schedule1_reg       <= ipvs_pkg::SLOT_UNSET;
            schedule2_reg       <= ipvs_pkg::SLOT_UNSET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ipvs_pkg::REG_SOIL_THRESHOLD:  soil_threshold_reg  <= cfg_data[6:0];
                ipvs_pkg::REG_LIGHT_THRESHOLD: light_threshold_reg <= cfg_data;
                ipvs_pkg::REG_AUTO_OFF:        auto_off_reg        <= cfg_data;
                ipvs_pkg::REG_SCHEDULE1:       schedule1_reg       <= cfg_data[10:0];
                ipvs_pkg::REG_SCHEDULE2:       schedule2_reg       <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (!item_stall)
        begin
            stage_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            command_reg <= command;
            zone_reg    <= zone;
            soil_reg    <= soil_tenths;
            lux_reg     <= lux;
            hour_reg    <= clock_hour;
            minute_reg  <= clock_minute;
            day_reg     <= clock_day;
            switch_reg  <= switch_value;
        end
    end

    function automatic logic any_dry(input ipvs_pkg::seq_state_t s);
        logic dry;
        dry = 1'b0;
        for (int z = 1; z < 4; z++)
        begin
            if (3'(z) <= ZONE_LIMIT && s.zone_dry[z])
            begin
                dry = 1'b1;
            end
        end
        return dry;
    endfunction

    function automatic ipvs_pkg::seq_state_t pump_start(input ipvs_pkg::seq_state_t s);
        ipvs_pkg::seq_state_t r;
        r             = s;
        r.pump        = 1'b1;
        r.stop_wait   = 1'b0;
        r.stop_ticks  = '0;
        r.marks       = 2'b00;
        r.start_wait  = 1'b0;
        r.start_ticks = '0;
        if (auto_off_reg != 16'd0)
        begin
            r.auto_left = auto_off_reg;
        end
        return r;
    endfunction

    function automatic ipvs_pkg::seq_state_t valve_drive(input ipvs_pkg::seq_state_t s,
                                                         input int v, input logic on);
        ipvs_pkg::seq_state_t r;
        r          = s;
        r.valve[v] = on;
        if (on && !s.pump && !s.start_wait)
        begin
            r.start_wait  = 1'b1;
            r.start_ticks = '0;
        end
        return r;
    endfunction

    function automatic ipvs_pkg::seq_state_t shutdown(input ipvs_pkg::seq_state_t s);
        ipvs_pkg::seq_state_t r;
        r = s;
        if (s.pump)
        begin
            r.pump       = 1'b0;
            r.stop_wait  = 1'b1;
            r.stop_ticks = '0;
            r.marks      = s.valve;
        end
        else
        begin
            r.valve = s.valve & s.marks;
        end
        return r;
    endfunction

    function automatic logic slot_hit(input logic [10:0] slot, input logic [4:0] h,
                                      input logic [5:0] m);
        logic [11:0] minute_of_day;
        minute_of_day = ({7'd0, h} << 6) - ({7'd0, h} << 2) + {6'd0, m};
        return (slot < ipvs_pkg::SLOT_UNSET) && (m < ipvs_pkg::MINUTES_PER_HOUR)
               && (minute_of_day == {1'b0, slot});
    endfunction

    function automatic ipvs_pkg::seq_state_t tick(input ipvs_pkg::seq_state_t s);
        ipvs_pkg::seq_state_t r;
        logic go;
        r = s;
        if (r.start_wait)
        begin
            if (r.start_ticks < DELAY)
            begin
                r.start_ticks = r.start_ticks + 1'b1;
            end
            if (r.start_ticks >= DELAY)
            begin
                r.start_wait  = 1'b0;
                r.start_ticks = '0;
                if (!r.pump)
                begin
                    go = r.mode ? (r.valve != 2'b00) : any_dry(r);
                    if (go)
                    begin
                        r = pump_start(r);
                    end
                end
            end
        end
        if (r.stop_wait)
        begin
            if (r.stop_ticks < DELAY)
            begin
                r.stop_ticks = r.stop_ticks + 1'b1;
            end
            if (r.stop_ticks >= DELAY)
            begin
                r.valve      = r.valve & ~r.marks;
                r.stop_wait  = 1'b0;
                r.stop_ticks = '0;
                r.marks      = 2'b00;
            end
        end
        if (r.auto_left != 16'd0)
        begin
            r.auto_left = r.auto_left - 16'd1;
            if (r.auto_left == 16'd0)
            begin
                r = shutdown(r);
            end
        end
        return r;
    endfunction

    function automatic ipvs_pkg::seq_state_t soil_report(input ipvs_pkg::seq_state_t s,
                                                         input logic [1:0] z,
                                                         input logic [9:0] soil);
        ipvs_pkg::seq_state_t r;
        logic [10:0] limit;
        r     = s;
        limit = 11'(soil_threshold_reg) * 11'd10;
        if (!r.mode && {1'b0, z} <= ZONE_LIMIT)
        begin
            if ({1'b0, soil} < limit)
            begin
                if (r.light > light_threshold_reg)
                begin
                    r.zone_dry[z] = 1'b0;
                end
                else
                begin
                    r.zone_dry[z] = 1'b1;
                    if (z == 2'd1)
                    begin
                        r = valve_drive(r, 0, 1'b1);
                    end
                    else if (z == 2'd2)
                    begin
                        r = valve_drive(r, 1, 1'b1);
                    end
                end
            end
            else
            begin
                r.zone_dry[z] = 1'b0;
                if (z == 2'd1 && r.valve[0])
                begin
                    r.marks[0] = 1'b1;
                end
                else if (z == 2'd2 && r.valve[1])
                begin
                    r.marks[1] = 1'b1;
                end
                if (!any_dry(r) && r.pump)
                begin
                    r = shutdown(r);
                end
            end
        end
        return r;
    endfunction

    function automatic ipvs_pkg::seq_state_t clock_reading(input ipvs_pkg::seq_state_t s,
                                                           input logic [4:0] h,
                                                           input logic [5:0] m,
                                                           input logic [4:0] d);
        ipvs_pkg::seq_state_t r;
        r = s;
        if (r.mode)
        begin
            if (r.last_day != {1'b0, d})
            begin
                r.watered  = 2'b00;
                r.last_day = {1'b0, d};
            end
            if (slot_hit(schedule1_reg, h, m) && !r.watered[0])
            begin
                r.watered[0] = 1'b1;
                r = valve_drive(r, 0, 1'b1);
                r = valve_drive(r, 1, 1'b1);
            end
            if (slot_hit(schedule2_reg, h, m) && !r.watered[1])
            begin
                r.watered[1] = 1'b1;
                r = valve_drive(r, 0, 1'b1);
                r = valve_drive(r, 1, 1'b1);
            end
        end
        return r;
    endfunction

    always_comb
    begin
        state_next = state_reg;
        case (ipvs_pkg::cmd_t'(command_reg))
            ipvs_pkg::CMD_TICK:   state_next = tick(state_reg);
            ipvs_pkg::CMD_SOIL:   state_next = soil_report(state_reg, zone_reg, soil_reg);
            ipvs_pkg::CMD_LIGHT:  state_next.light = lux_reg;
            ipvs_pkg::CMD_CLOCK:
                state_next = clock_reading(state_reg, hour_reg, minute_reg, day_reg);
            ipvs_pkg::CMD_PUMP:
                state_next = switch_reg ? pump_start(state_reg) : shutdown(state_reg);
            ipvs_pkg::CMD_VALVE1: state_next = valve_drive(state_reg, 0, switch_reg);
            ipvs_pkg::CMD_VALVE2: state_next = valve_drive(state_reg, 1, switch_reg);
            ipvs_pkg::CMD_MODE:
            begin
                state_next.mode        = switch_reg;
                state_next             = shutdown(state_next);
                state_next.start_wait  = 1'b0;
                state_next.start_ticks = '0;
                if (switch_reg)
                begin
                    state_next.watered = 2'b00;
                end
                else
                begin
                    state_next.zone_dry = 4'b0000;
                end
            end
            default: state_next = state_reg;
        endcase
        result_next = {state_next.pump, state_next.valve[0], state_next.valve[1],
                       state_next.start_wait, state_next.stop_wait};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ipvs_pkg::STATE_RESET;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                state_reg <= state_next;
            end
            if (advance)
            begin
                result_valid_reg <= stage_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid  = result_valid_reg;
    assign pump_on       = result_reg[4];
    assign valve1_on     = result_reg[3];
    assign valve2_on     = result_reg[2];
    assign start_pending = result_reg[1];
    assign stop_pending  = result_reg[0];

    a_pump_no_stop: assert property (@(posedge clk) disable iff (!rst_n)
        !(state_reg.pump && state_reg.stop_wait))
        else $error("pump running with stop delay armed");

    a_pump_no_start: assert property (@(posedge clk) disable iff (!rst_n)
        !(state_reg.pump && state_reg.start_wait))
        else $error("pump running with start delay armed");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.start_wait |-> state_reg.start_ticks == '0)
        else $error("start count left over");

    a_stop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.stop_wait |-> state_reg.stop_ticks == '0)
        else $error("stop count left over");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |=> stage_valid_reg && $stable(command_reg))
        else $error("held transfer lost");

endmodule
